// File: hdl/ota_pkg.sv
// Shared types, constants and helpers of the token atom encoder.
`default_nettype none

package ota_pkg;

  // Width of the tracked write position
  localparam int unsigned POS_BITS = 16;
  // Width for position plus token size sums
  localparam int unsigned SUM_W    = POS_BITS + 13;
  localparam int unsigned NEED_W   = 12;
  localparam int unsigned DATA_W   = 72;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Token kinds
  localparam logic [2:0] KIND_RAW      = 3'd0;
  localparam logic [2:0] KIND_NUMBER   = 3'd1;
  localparam logic [2:0] KIND_STR_HDR  = 3'd2;
  localparam logic [2:0] KIND_STR_DATA = 3'd3;
  localparam logic [2:0] KIND_RESTART  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b1;

  // Register reset values
  localparam logic [15:0] CAPACITY_RST = 16'd2048;
  localparam logic [7:0]  START_RST    = 8'd56;

  // Atom headers
  localparam logic [7:0] HDR_SHORT1   = 8'h81;
  localparam logic [7:0] HDR_SHORT2   = 8'h82;
  localparam logic [7:0] HDR_SHORT4   = 8'h84;
  localparam logic [7:0] HDR_SHORT8   = 8'h88;
  localparam logic [7:0] HDR_NULL     = 8'hA1;
  localparam logic [7:0] HDR_TINY_STR = 8'hA0;
  localparam logic [7:0] HDR_MEDIUM   = 8'hD0;

  // One token's worth of output bytes, MSB byte first
  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [CNT_W-1:0]    cnt;
    logic                wr;
    logic [1:0]          status;
    logic [POS_BITS-1:0] pos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Report a position as the 16-bit result field
  function automatic logic [15:0] pos_out(input logic [POS_BITS-1:0] p);
    logic [SUM_W-1:0] w;
    w = SUM_W'(p);
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/opal_token_atom_encoder.sv
// Top level of the token atom encoder.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one token per beat: a raw
//   byte, a number, a string header, a string data byte or a restart.
//   Output channel (out_valid_o / out_stall_i) carries one result per beat;
//   last_o marks the final result of a token. A number yields up to nine
//   beats, a string header up to two, every other token one.
//   A token's first result passes through the queue, job and output registers.
//   Throughput: one output beat per cycle while the receiver does not stall,
//   limited by the single byte lane of the back end; a two-entry job queue
//   lets tokens enter back to back while earlier tokens still drain.
//   Room checks and position tracking happen in the front end at accept.
//   Configuration (capacity, start offset) is written via cfg_we_i; the user
//   must do so only with no token in flight, which the block does not check.
//   Reset restores capacity 2048, start offset 56 and position 56, and empties
//   the queue and output register. When the receiver stalls, the output beat
//   holds; once the queue fills, in_stall_o rises until an entry frees up.
`default_nettype none

module opal_token_atom_encoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ota_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ota_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [2:0]                        kind_i,
  input  wire logic [63:0]                       value_i,
  input  wire logic [11:0]                       length_i,
  input  wire logic [7:0]                        data_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [7:0]                             out_byte_o,
  output logic                                   byte_valid_o,
  output logic                                   last_o,
  output logic [1:0]                             status_o,
  output logic [15:0]                            position_o
);

  ota_pkg::q_stat_t q_stat;
  ota_pkg::job_t    push_job, pop_job;
  logic             push, pop;

  assign in_stall_o = q_stat.full;

  ota_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .length_i    (length_i),
    .data_byte_i (data_byte_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  ota_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .stat_o     (q_stat)
  );

  ota_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .status_o     (status_o),
    .position_o   (position_o)
  );

endmodule

`default_nettype wire

// File: hdl/ota_front.sv
// Front end: takes tokens, checks room, tracks position and string state.
`default_nettype none

module ota_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ota_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [ota_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  input  wire logic [2:0]                           kind_i,
  input  wire logic [63:0]                          value_i,
  input  wire logic [11:0]                          length_i,
  input  wire logic [7:0]                           data_byte_i,
  input  wire ota_pkg::q_stat_t                     q_stat_i,
  output logic                                      push_o,
  output ota_pkg::job_t                             job_o
);

  logic [15:0]                      capacity_q;
  logic [7:0]                       start_q;
  logic [ota_pkg::POS_BITS-1:0]     pos_q, pos_d;
  logic [10:0]                      left_q, left_d;

  logic [ota_pkg::CNT_W-1:0]        num_cnt;
  logic [ota_pkg::DATA_W-1:0]       num_data;
  logic [ota_pkg::NEED_W-1:0]       need;
  logic [ota_pkg::SUM_W-1:0]        cap_full, cap_mask, cap_eff, sum;
  logic                             fits;
  logic [10:0]                      len;
  logic                             str_zero, str_tiny;

  assign push_o = in_valid_i && !q_stat_i.full;

  // Classify a number by its significant bytes
  always_comb begin
    if (value_i[63:6] == '0) begin
      num_cnt  = 4'd1;
      num_data = {2'b00, value_i[5:0], 64'd0};
    end else if (value_i[63:8] == '0) begin
      num_cnt  = 4'd2;
      num_data = {ota_pkg::HDR_SHORT1, value_i[7:0], 56'd0};
    end else if (value_i[63:16] == '0) begin
      num_cnt  = 4'd3;
      num_data = {ota_pkg::HDR_SHORT2, value_i[15:0], 48'd0};
    end else if (value_i[63:32] == '0) begin
      num_cnt  = 4'd5;
      num_data = {ota_pkg::HDR_SHORT4, value_i[31:0], 32'd0};
    end else begin
      num_cnt  = 4'd9;
      num_data = {ota_pkg::HDR_SHORT8, value_i};
    end
  end

  assign len      = length_i[10:0];
  assign str_zero = (len == '0);
  assign str_tiny = (len[10:4] == '0);

  // Bytes the token needs in the buffer
  always_comb begin
    unique case (kind_i)
      ota_pkg::KIND_NUMBER:  need = ota_pkg::NEED_W'(num_cnt);
      ota_pkg::KIND_STR_HDR: begin
        if (str_zero)      need = 12'd2;
        else if (str_tiny) need = ota_pkg::NEED_W'(len) + 12'd1;
        else               need = ota_pkg::NEED_W'(len) + 12'd2;
      end
      default:               need = 12'd1;
    endcase
  end

  // Compare against capacity clipped to the position range
  assign cap_full = ota_pkg::SUM_W'(capacity_q);
  assign cap_mask = ota_pkg::SUM_W'({ota_pkg::POS_BITS{1'b1}});
  assign cap_eff  = (cap_full > cap_mask) ? cap_mask : cap_full;
  assign sum      = ota_pkg::SUM_W'(pos_q) + ota_pkg::SUM_W'(need);
  assign fits     = (sum <= cap_eff);

  // Build the job and the next state
  always_comb begin
    pos_d      = pos_q;
    left_d     = left_q;
    job_o      = '0;
    job_o.cnt  = 4'd1;
    job_o.wr   = 1'b0;
    job_o.status = ota_pkg::ST_OK;
    job_o.pos  = pos_q;
    unique case (kind_i)
      ota_pkg::KIND_RAW: begin
        if (fits) begin
          job_o.wr   = 1'b1;
          job_o.data = {data_byte_i, 64'd0};
          pos_d      = pos_q + ota_pkg::POS_BITS'(1);
        end else begin
          job_o.status = ota_pkg::ST_NO_ROOM;
        end
      end
      ota_pkg::KIND_NUMBER: begin
        if (fits) begin
          job_o.wr   = 1'b1;
          job_o.cnt  = num_cnt;
          job_o.data = num_data;
          pos_d      = pos_q + ota_pkg::POS_BITS'(num_cnt);
        end else begin
          job_o.status = ota_pkg::ST_NO_ROOM;
        end
      end
      ota_pkg::KIND_STR_HDR: begin
        left_d = '0;
        if (length_i[11]) begin
          job_o.status = ota_pkg::ST_TOO_LONG;
        end else if (!fits) begin
          job_o.status = ota_pkg::ST_NO_ROOM;
        end else if (str_zero) begin
          job_o.wr   = 1'b1;
          job_o.cnt  = 4'd2;
          job_o.data = {ota_pkg::HDR_NULL, 8'h00, 56'd0};
          pos_d      = pos_q + ota_pkg::POS_BITS'(2);
        end else if (str_tiny) begin
          job_o.wr   = 1'b1;
          job_o.data = {ota_pkg::HDR_TINY_STR | {4'd0, len[3:0]}, 64'd0};
          pos_d      = pos_q + ota_pkg::POS_BITS'(1);
          left_d     = len;
        end else begin
          job_o.wr   = 1'b1;
          job_o.cnt  = 4'd2;
          job_o.data = {ota_pkg::HDR_MEDIUM | {5'd0, len[10:8]}, len[7:0], 56'd0};
          pos_d      = pos_q + ota_pkg::POS_BITS'(2);
          left_d     = len;
        end
      end
      ota_pkg::KIND_STR_DATA: begin
        if (left_q != '0) begin
          if (fits) begin
            job_o.wr   = 1'b1;
            job_o.data = {data_byte_i, 64'd0};
            pos_d      = pos_q + ota_pkg::POS_BITS'(1);
            left_d     = left_q - 11'd1;
          end else begin
            job_o.status = ota_pkg::ST_NO_ROOM;
          end
        end
      end
      ota_pkg::KIND_RESTART: begin
        pos_d     = ota_pkg::POS_BITS'(start_q);
        left_d    = '0;
        job_o.pos = ota_pkg::POS_BITS'(start_q);
      end
      default: begin
        job_o.status = ota_pkg::ST_OK;
      end
    endcase
  end

  // Hold registers and token state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= ota_pkg::CAPACITY_RST;
      start_q    <= ota_pkg::START_RST;
      pos_q      <= ota_pkg::POS_BITS'(ota_pkg::START_RST);
      left_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ota_pkg::CFG_CAPACITY:     capacity_q <= cfg_wdata_i[15:0];
          ota_pkg::CFG_START_OFFSET: start_q    <= cfg_wdata_i[7:0];
          default:                   start_q    <= start_q;
        endcase
      end
      if (push_o) begin
        pos_q  <= pos_d;
        left_q <= left_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/ota_queue.sv
// Short job queue between the front and back ends.
`default_nettype none

module ota_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ota_pkg::job_t     push_job_i,
  input  wire logic              pop_i,
  output ota_pkg::job_t          pop_job_o,
  output ota_pkg::q_stat_t       stat_o
);

  localparam int unsigned CntW = $clog2(ota_pkg::Q_DEPTH + 1);

  ota_pkg::job_t                  mem_q [ota_pkg::Q_DEPTH];
  logic [ota_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                count_q;

  assign stat_o.full  = (count_q == CntW'(ota_pkg::Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_job_o    = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == ota_pkg::Q_PTR_W'(ota_pkg::Q_DEPTH - 1))
                    ? '0 : wr_ptr_q + ota_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == ota_pkg::Q_PTR_W'(ota_pkg::Q_DEPTH - 1))
                    ? '0 : rd_ptr_q + ota_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full && !pop_i |-> !push_i)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// File: hdl/ota_back.sv
// Back end: serializes queued jobs into one output beat per byte, or one byteless beat.
`default_nettype none

module ota_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ota_pkg::q_stat_t   q_stat_i,
  input  wire ota_pkg::job_t      job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    byte_valid_o,
  output logic                    last_o,
  output logic [1:0]              status_o,
  output logic [15:0]             position_o
);

  logic                           busy_q;
  logic [ota_pkg::DATA_W-1:0]     data_q;
  logic [ota_pkg::CNT_W-1:0]      cnt_q;
  logic                           wr_q;
  logic [1:0]                     status_q;
  logic [ota_pkg::POS_BITS-1:0]   pos_q, pos_next;

  logic                           out_valid_q;
  logic                           issue, done;

  assign out_valid_o = out_valid_q;
  assign issue       = busy_q && (!out_valid_q || !out_stall_i);
  assign done        = !busy_q || (issue && cnt_q == ota_pkg::CNT_W'(1));
  assign pop_o       = done && !q_stat_i.empty;
  assign pos_next    = wr_q ? pos_q + ota_pkg::POS_BITS'(1) : pos_q;

  // Load jobs and step through their bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= job_i.cnt;
      end else if (done) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else if (issue) begin
        cnt_q  <= cnt_q - ota_pkg::CNT_W'(1);
      end
    end
  end

  // Job payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q   <= job_i.data;
      wr_q     <= job_i.wr;
      status_q <= job_i.status;
      pos_q    <= job_i.pos;
    end else if (issue) begin
      data_q   <= data_q << 8;
      pos_q    <= pos_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_byte_o   <= wr_q ? data_q[ota_pkg::DATA_W-1 -: 8] : 8'd0;
      byte_valid_o <= wr_q;
      last_o       <= (cnt_q == ota_pkg::CNT_W'(1));
      status_o     <= status_q;
      position_o   <= ota_pkg::pos_out(pos_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("active job with zero byte count");
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o && out_byte_o == 8'd0)
    else $error("result without byte must be single and zero");
`endif

endmodule

`default_nettype wire
